FILE: rtl/core/slfx_pkg.sv
package slfx_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int INCR_BITS           = 32;
	localparam int GAIN_BITS           = 16;
	localparam int Q30_SHIFT           = 30;
	localparam int HALF_SHIFT          = 15;
	localparam int GAIN_SHIFT          = 16;
	localparam longint ONE_Q30         = 64'sd1 << Q30_SHIFT;
	localparam int HALF_SCALE          = 32768;
	localparam int GAIN_MAX            = 65535;

	// quarter-wave sine polynomial in Q30, highest degree first
	localparam longint SINE_COEF [7] = '{
		64'sd61, -64'sd3864, 64'sd172272, -64'sd5026995,
		64'sd85569306, -64'sd693598666, 64'sd1686629713
	};

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} stage_en_t;

	// (a * b) >> 30, truncated toward zero, b nonnegative
	function automatic longint mul_q30(longint a, longint b);
		longint m;
		if (a < 0) begin
			m = ((-a) * b) >>> Q30_SHIFT;
			return -m;
		end
		m = (a * b) >>> Q30_SHIFT;
		return m;
	endfunction

	// round(32768 * sin(pi/2 * pos / 2^qb)), elaboration only
	function automatic logic [GAIN_BITS-1:0] quarter_half(int pos, int qb);
		longint u;
		longint u2;
		longint acc;
		longint h;
		u   = longint'(pos) <<< (Q30_SHIFT - qb);
		u2  = mul_q30(u, u);
		acc = SINE_COEF[0];
		for (int i = 1; i < 7; i++) begin
			acc = SINE_COEF[i] + mul_q30(acc, u2);
		end
		acc = mul_q30(acc, u);
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > ONE_Q30) begin
			acc = ONE_Q30;
		end
		h = (acc + (64'sd1 <<< (HALF_SHIFT - 1))) >>> HALF_SHIFT;
		return GAIN_BITS'(h);
	endfunction

endpackage

FILE: rtl/core/slfx_phase.sv
module slfx_phase #(
	parameter int PHASE_BITS      = slfx_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = slfx_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [slfx_pkg::INCR_BITS-1:0]   cfg_data,
	input  logic                             take,
	input  slfx_pkg::stage_en_t              en,
	output logic [TABLE_ADDR_BITS-2:0]       pos_s1,
	output logic                             inv_s1
);

	localparam int QB = TABLE_ADDR_BITS - 2;
	localparam int WW = (PHASE_BITS > slfx_pkg::INCR_BITS) ? PHASE_BITS : slfx_pkg::INCR_BITS;

	logic [slfx_pkg::INCR_BITS-1:0] incr_q;
	logic [PHASE_BITS-1:0]          phase_q;
	logic [WW-1:0]                  incr_w;
	logic [PHASE_BITS-1:0]          incr_p;
	logic [TABLE_ADDR_BITS-1:0]     addr;
	logic [QB:0]                    rem;
	logic [QB:0]                    pos;

	assign incr_w = WW'(incr_q);
	assign incr_p = incr_w[PHASE_BITS-1:0];
	assign addr   = phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];
	assign rem    = {1'b0, addr[QB-1:0]};

	// odd quarters run the table backwards
	always_comb begin
		if (addr[QB]) begin
			pos = (QB+1)'(1 << QB) - rem;
		end else begin
			pos = rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_q  <= '0;
			phase_q <= '0;
		end else begin
			if (cfg_valid) begin
				incr_q <= cfg_data;
			end
			if (take) begin
				phase_q <= phase_q + incr_p;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			pos_s1 <= pos;
			inv_s1 <= addr[QB+1];
		end
	end

endmodule

FILE: rtl/core/slfx_gain.sv
module slfx_gain #(
	parameter int TABLE_ADDR_BITS = slfx_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  slfx_pkg::stage_en_t                 en,
	input  logic [TABLE_ADDR_BITS-2:0]          pos_s1,
	input  logic                                inv_s1,
	output logic [slfx_pkg::GAIN_BITS-1:0]      gain
);

	localparam int QB    = TABLE_ADDR_BITS - 2;
	localparam int DEPTH = (1 << QB) + 1;
	localparam int GB    = slfx_pkg::GAIN_BITS;

	logic [GB-1:0] rom [DEPTH];
	logic [GB-1:0] half_s2;
	logic          inv_s2;
	logic [GB:0]   sum;

	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam logic [GB-1:0] ENTRY = slfx_pkg::quarter_half(k, QB);
		assign rom[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			half_s2 <= rom[pos_s1];
			inv_s2  <= inv_s1;
		end
	end

	always_comb begin
		if (inv_s2) begin
			sum = (GB+1)'(slfx_pkg::HALF_SCALE) - {1'b0, half_s2};
		end else begin
			sum = (GB+1)'(slfx_pkg::HALF_SCALE) + {1'b0, half_s2};
		end
		// full gain held one below unity
		if (sum[GB]) begin
			gain = GB'(slfx_pkg::GAIN_MAX);
		end else begin
			gain = sum[GB-1:0];
		end
	end

endmodule

FILE: rtl/core/slfx_mix.sv
module slfx_mix #(
	parameter int SAMPLE_BITS = slfx_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  slfx_pkg::stage_en_t               en,
	input  logic signed [SAMPLE_BITS-1:0]     sample_a,
	input  logic signed [SAMPLE_BITS-1:0]     sample_b,
	input  logic                              block_last,
	input  logic [slfx_pkg::GAIN_BITS-1:0]    gain,
	output logic [SAMPLE_BITS-1:0]            mixed_q,
	output logic                              block_end_q
);

	localparam int SB = SAMPLE_BITS;
	localparam int GB = slfx_pkg::GAIN_BITS;
	localparam int PW = SB + GB + 2;

	logic signed [SB-1:0] a_s1;
	logic signed [SB-1:0] b_s1;
	logic                 last_s1;
	logic signed [SB:0]   diff_s2;
	logic signed [SB-1:0] b_s2;
	logic                 last_s2;
	logic signed [PW-1:0] prod_s3;
	logic signed [SB-1:0] b_s3;
	logic                 last_s3;
	logic signed [PW-1:0] rnd;
	logic signed [SB+1:0] mix;

	assign rnd = prod_s3 + PW'(1 << (slfx_pkg::GAIN_SHIFT - 1));
	assign mix = $signed(rnd[PW-1:slfx_pkg::GAIN_SHIFT]) + (SB+2)'(b_s3);

	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			a_s1    <= sample_a;
			b_s1    <= sample_b;
			last_s1 <= block_last;
		end
		if (en.ld_s2) begin
			diff_s2 <= (SB+1)'(a_s1) - (SB+1)'(b_s1);
			b_s2    <= b_s1;
			last_s2 <= last_s1;
		end
		if (en.ld_s3) begin
			prod_s3 <= $signed({1'b0, gain}) * diff_s2;
			b_s3    <= b_s2;
			last_s3 <= last_s2;
		end
		if (en.ld_out) begin
			mixed_q     <= mix[SB-1:0];
			block_end_q <= last_s3;
		end
	end

endmodule

FILE: rtl/core/sine_lfo_crossfader_unit.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata a,b  tlast block_last
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata mixed  tlast block_end
// cfg       in   cfg_valid/cfg_ready            cfg_data phase_increment
//
// One request per cycle sustained unless m_axis_tready stalls the output.
// Stages: phase/address, sine table read, gain and multiply, round and add.
// Each stage advances whenever the one after it is empty or advancing.
// arst_n clears phase, increment and all stage valids.
module sine_lfo_crossfader_unit #(
	parameter int PHASE_BITS      = slfx_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = slfx_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = slfx_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W           = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W          = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [IN_W-1:0]                s_axis_tdata,  // sample_a, sample_b
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [OUT_W-1:0]               m_axis_tdata,  // mixed_sample
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slfx_pkg::INCR_BITS-1:0] cfg_data
);

	slfx_pkg::stage_en_t          en;
	logic                         v_s1;
	logic                         v_s2;
	logic                         v_s3;
	logic                         vo_q;
	logic                         take;
	logic [TABLE_ADDR_BITS-2:0]   pos_s1;
	logic                         inv_s1;
	logic [slfx_pkg::GAIN_BITS-1:0] gain;
	logic [SAMPLE_BITS-1:0]       mixed_q;
	logic                         block_end_q;

	always_comb begin
		en.ld_out = !vo_q || m_axis_tready;
		en.ld_s3  = !v_s3 || en.ld_out;
		en.ld_s2  = !v_s2 || en.ld_s3;
		en.ld_s1  = !v_s1 || en.ld_s2;
	end

	assign s_axis_tready = en.ld_s1;
	assign take          = s_axis_tvalid && en.ld_s1;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = OUT_W'(mixed_q);
	assign m_axis_tlast  = block_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en.ld_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en.ld_s2) begin
				v_s2 <= v_s1;
			end
			if (en.ld_s3) begin
				v_s3 <= v_s2;
			end
			if (en.ld_out) begin
				vo_q <= v_s3;
			end
		end
	end

	slfx_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.take      (take),
		.en        (en),
		.pos_s1    (pos_s1),
		.inv_s1    (inv_s1)
	);

	slfx_gain #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_gain (
		.clk    (clk),
		.en     (en),
		.pos_s1 (pos_s1),
		.inv_s1 (inv_s1),
		.gain   (gain)
	);

	slfx_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk         (clk),
		.en          (en),
		.sample_a    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.sample_b    (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.block_last  (s_axis_tlast),
		.gain        (gain),
		.mixed_q     (mixed_q),
		.block_end_q (block_end_q)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && vo_q && !m_axis_tready))
		else $error("input stalled with a free stage");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_s1)
		else $error("accepted request lost at first stage");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_s3))
		else $error("result without a request behind it");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en.ld_out) |=> m_axis_tvalid)
		else $error("third stage request not moved to output");

endmodule

FILE: tb/sv/tb_sine_lfo_crossfader_unit.sv
`timescale 1ns / 1ps

module tb_sine_lfo_crossfader_unit;

	localparam int SW         = slfx_pkg::SAMPLE_BITS_DEF;
	localparam int PW         = slfx_pkg::PHASE_BITS_DEF;
	localparam int AW         = slfx_pkg::TABLE_ADDR_BITS_DEF;
	localparam int QB         = AW - 2;
	localparam int IN_W       = ((2 * SW + 7) / 8) * 8;
	localparam int OUT_W      = ((SW + 7) / 8) * 8;
	localparam int RAND_ITEMS = 704;
	localparam int N_PHASES   = 8;
	localparam int SETTLE     = 8;
	localparam int MAX_CYCLES = 400000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic signed [SW-1:0] a;
		logic signed [SW-1:0] b;
		logic                 last;
	} sample_pair_t;

	typedef struct {
		logic [SW-1:0] mixed;
		logic          last;
	} mix_result_t;

	// quarter-wave sine polynomial in Q30, highest degree first
	localparam longint SIN_Q30 [7] = '{
		61, -3864, 172272, -5026995, 85569306, -693598666, 1686629713
	};

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;   // sample_a, sample_b
	logic              s_axis_tlast  = 1'b0; // block_last
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;         // mixed_sample
	logic              m_axis_tlast;         // block_end
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [slfx_pkg::INCR_BITS-1:0] cfg_data = '0;

	sample_pair_t pending_pairs [$];
	mix_result_t  expected_mix [$];
	sample_pair_t pair_on_bus;
	mix_result_t  got_mix;
	mix_result_t  want_mix;

	logic [PW-1:0]                  lfo_phase;
	logic [slfx_pkg::INCR_BITS-1:0] lfo_incr;
	idle_mode_t           idle_mode = IDLE_NONE;
	int                   mismatches = 0;
	int                   cycles = 0;

	sine_lfo_crossfader_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// (a * b) >> 30 toward zero, b nonnegative
	function automatic longint fix_mul30(longint a, longint b);
		longint unsigned p;
		if (a < 0) begin
			p = (unsigned'(-a) * unsigned'(b)) >> 30;
			return -longint'(p);
		end
		p = (unsigned'(a) * unsigned'(b)) >> 30;
		return longint'(p);
	endfunction

	function automatic longint lfo_gain(int unsigned k);
		int unsigned quad;
		int unsigned r;
		int unsigned pos;
		longint u;
		longint u2;
		longint acc;
		longint half;
		longint g;
		quad = (k >> QB) & 3;
		r    = k & ((1 << QB) - 1);
		pos  = quad[0] ? ((1 << QB) - r) : r;
		u    = longint'(pos) << (30 - QB);
		u2   = fix_mul30(u, u);
		acc  = SIN_Q30[0];
		for (int i = 1; i < 7; i++) begin
			acc = SIN_Q30[i] + fix_mul30(acc, u2);
		end
		acc = fix_mul30(acc, u);
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (64'sd1 << 30)) begin
			acc = 64'sd1 << 30;
		end
		half = (acc + 16384) >>> 15;
		g = quad[1] ? (32768 - half) : (32768 + half);
		if (g < 0) begin
			g = 0;
		end
		if (g > 65535) begin
			g = 65535;
		end
		return g;
	endfunction

	// mix for the current phase, then advance the phase
	function automatic mix_result_t crossfade(sample_pair_t p);
		mix_result_t res;
		longint gain;
		longint diff;
		longint mix;
		gain = lfo_gain(int'(lfo_phase >> (PW - AW)));
		diff = longint'(p.a) - longint'(p.b);
		mix  = longint'(p.b) + ((gain * diff + 32768) >>> 16);
		res.mixed = mix[SW-1:0];
		res.last  = p.last;
		lfo_phase = lfo_phase + PW'(lfo_incr);
		return res;
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(SW-1){1'b0}}};
			1: return {1'b0, {(SW-1){1'b1}}};
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int send_idle_pct(idle_mode_t m);
		case (m)
			IDLE_SEND: return 69;
			IDLE_BOTH: return 11;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(idle_mode_t m);
		case (m)
			IDLE_RECV: return 69;
			IDLE_BOTH: return 11;
			default:   return 0;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			lfo_phase     = '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_mix.push_back(crossfade(pair_on_bus));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pairs.size() != 0 && !roll(send_idle_pct(idle_mode))) begin
					pair_on_bus = pending_pairs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= IN_W'({pair_on_bus.b, pair_on_bus.a});
					s_axis_tlast  <= pair_on_bus.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_mix.mixed = m_axis_tdata[SW-1:0];
				got_mix.last  = m_axis_tlast;
				if (expected_mix.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result: mixed %0d last %0b",
							$signed(got_mix.mixed), got_mix.last);
					end
				end else begin
					want_mix = expected_mix.pop_front();
					if (got_mix.mixed !== want_mix.mixed || got_mix.last !== want_mix.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: mixed exp %0d got %0d, last exp %0b got %0b",
								$signed(want_mix.mixed), $signed(got_mix.mixed),
								want_mix.last, got_mix.last);
						end
					end
				end
			end
			m_axis_tready <= !roll(recv_stall_pct(idle_mode));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_increment(input logic [slfx_pkg::INCR_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		lfo_incr = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (pending_pairs.size() != 0 || s_axis_tvalid || expected_mix.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_pair(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b,
		input logic last);
		sample_pair_t p;
		p.a    = a;
		p.b    = b;
		p.last = last;
		pending_pairs.push_back(p);
	endtask

	initial begin
		logic [slfx_pkg::INCR_BITS-1:0] incr_plan [N_PHASES];
		logic signed [SW-1:0] s_min;
		logic signed [SW-1:0] s_max;
		lfo_incr = '0;
		s_min = {1'b1, {(SW-1){1'b0}}};
		s_max = {1'b0, {(SW-1){1'b1}}};
		incr_plan = '{
			32'h8000_0000, 32'd1, 32'h0040_0000, 32'h0,
			32'h0, 32'h0000_1234, 32'h0, 32'h8000_0000
		};
		incr_plan[3] = $urandom_range(0, 32'h8000_0000);
		incr_plan[6] = $urandom_range(0, 32'h0100_0000);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero increment: phase zero, gain one half
		queue_pair(s_min, s_max, 1'b0);
		queue_pair(s_max, s_min, 1'b1);
		queue_pair(16'sd1, -16'sd1, 1'b0);
		queue_pair(-16'sd1, 16'sd0, 1'b1);
		wait_drained();

		// quarter-cycle steps: mid gain, full gain held below one, mid, zero gain
		write_increment(32'h4000_0000);
		for (int i = 0; i < 4; i++) begin
			queue_pair(s_min, s_max, 1'b0);
			queue_pair(s_max, s_min, 1'b1);
			queue_pair(s_max, s_max, 1'b0);
			queue_pair(16'sd0, 16'sd0, 1'b1);
		end
		// half-cycle steps and wrap of the accumulator
		wait_drained();
		write_increment(32'hC000_0000 - 32'h4000_0000);
		queue_pair(s_min, s_max, 1'b1);
		queue_pair(s_max, s_min, 1'b0);
		queue_pair(-16'sd1, 16'sd1, 1'b1);
		wait_drained();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			idle_mode = idle_mode_t'(ph % 4);
			write_increment(incr_plan[ph]);
			for (int i = 0; i < RAND_ITEMS / N_PHASES; i++) begin
				queue_pair(pick_sample(), pick_sample(), 1'($urandom));
			end
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
